FILE: sv/two_button_id_editor_macros.svh
// two_button_id_editor_macros.svh: assertion macros shared by the editor RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef TWO_BUTTON_ID_EDITOR_MACROS_SVH
`define TWO_BUTTON_ID_EDITOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tbe_pkg.sv
// tbe_pkg: widths, reset values, codes, word types and ID helpers for the
// two-button ID editor. No dependencies.
package tbe_pkg;

  localparam int ID_W   = 7;
  localparam int TOUT_W = 16;
  localparam int INTV_W = 10;
  localparam int EVT_W  = 2;
  localparam int TIME_W = 32;
  localparam int MODE_W = 2;
  localparam int DIG_W  = 4;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MAX_VALUE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IDLE_TOUT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPEAT      = 3'd3;
  localparam logic [IDX_W-1:0] REG_SAVED_SLAT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SAVED_CTRL  = 3'd5;

  // Reset values
  localparam logic [ID_W-1:0]   RST_MAX_VALUE  = 7'd99;
  localparam logic [TOUT_W-1:0] RST_IDLE_TOUT  = 16'd3000;
  localparam logic [INTV_W-1:0] RST_DEBOUNCE   = 10'd175;
  localparam logic [INTV_W-1:0] RST_REPEAT     = 10'd50;
  localparam logic [ID_W-1:0]   RST_SAVED_ID   = 7'd0;

  // Editor modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SLAT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CTRL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd3;

  // Panel content codes
  localparam logic [MODE_W-1:0] PANEL_BLANK = 2'd0;
  localparam logic [MODE_W-1:0] PANEL_SLAT  = 2'd1;
  localparam logic [MODE_W-1:0] PANEL_CTRL  = 2'd2;

  // Reciprocal of ten for values below 128: (v * 205) >> 11
  localparam logic [14:0] RECIP10 = 15'd205;
  localparam int RECIP10_SH = 11;

  typedef struct packed {
    logic [ID_W-1:0]   max_value;
    logic [TOUT_W-1:0] idle_timeout_ms;
    logic [INTV_W-1:0] debounce_ms;
    logic [INTV_W-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [EVT_W-1:0]  up_event;
    logic [EVT_W-1:0]  down_event;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              poll_taken;
    logic [MODE_W-1:0] panel_mode;
    logic [DIG_W-1:0]  tens_digit;
    logic [DIG_W-1:0]  ones_digit;
    logic [ID_W-1:0]   slat_id;
    logic [ID_W-1:0]   control_id;
    logic              persist_strobe;
  } res_t;

  function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] v,
                                               input logic [ID_W-1:0] max_v);
    return (v > max_v) ? '0 : v;
  endfunction

  function automatic logic [ID_W-1:0] step_up(input logic [ID_W-1:0] v,
                                              input logic [ID_W-1:0] max_v);
    return (v >= max_v) ? '0 : ID_W'(v + 1'b1);
  endfunction

  function automatic logic [ID_W-1:0] step_down(input logic [ID_W-1:0] v,
                                                input logic [ID_W-1:0] max_v);
    return (v != '0) ? ID_W'(v - 1'b1) : max_v;
  endfunction

  function automatic logic [DIG_W-1:0] tens_of(input logic [ID_W-1:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * RECIP10;
    return DIG_W'(prod >> RECIP10_SH);
  endfunction

  function automatic logic [DIG_W-1:0] ones_of(input logic [ID_W-1:0] v);
    logic [DIG_W-1:0] t;
    logic [ID_W-1:0]  rem;
    t   = tens_of(v);
    rem = ID_W'(v - ID_W'({3'd0, t} * 7'd10));
    return rem[DIG_W-1:0];
  endfunction

endpackage

FILE: sv/two_button_id_editor.sv
// two_button_id_editor: top level; input register, result register, config.
// Depends on tbe_pkg, tbe_config, tbe_engine and two_button_id_editor_macros.svh.
//
// Use: each input word is one button poll (up_event, down_event, now_ms) on
// a valid/ready channel. Every accepted poll yields exactly one result word
// on the output channel: poll_taken, panel_mode, the two display digits,
// both working IDs and persist_strobe. A poll inside the current poll
// interval (debounce or repeat) reports poll_taken = 0 and changes nothing.
// Path: an accepted poll is held in the input register, stepped from there
// and lands in the result register, which raises out_valid. Throughput:
// one poll per cycle while the receiver does not stall, set by the
// combinational step between the two registers (the 32-bit time compare,
// the ID step and the digit split in series form the longest path).
// When the receiver stalls, the result register holds and the input register
// takes one more poll; in_ready then drops until out_ready returns.
// Reset (synchronous, rst high) empties both registers, puts the editor in
// idle with both IDs at zero and loads the default configuration.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered.
`include "two_button_id_editor_macros.svh"
module two_button_id_editor
  import tbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [EVT_W-1:0]  up_event,
  input  logic [EVT_W-1:0]  down_event,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              poll_taken,
  output logic [MODE_W-1:0] panel_mode,
  output logic [DIG_W-1:0]  tens_digit,
  output logic [DIG_W-1:0]  ones_digit,
  output logic [ID_W-1:0]   slat_id,
  output logic [ID_W-1:0]   control_id,
  output logic              persist_strobe,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  cfg_wr_t wr;
  item_t   in_word;
  logic    in_full;
  res_t    res, out_word;
  logic    adv;

  assign wr.we    = cfg_we;
  assign wr.index = cfg_index;
  assign wr.data  = cfg_data;

  // Step a held word whenever the result register is free or draining
  assign adv      = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || adv;

  // Hold the accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word.up_event   <= up_event;
      in_word.down_event <= down_event;
      in_word.now_ms     <= now_ms;
    end
  end

  tbe_config u_config (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .cfg (cfg)
  );

  tbe_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .wr   (wr),
    .adv  (adv),
    .item (in_word),
    .res  (res)
  );

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_word <= res;
  end

  assign poll_taken     = out_word.poll_taken;
  assign panel_mode     = out_word.panel_mode;
  assign tens_digit     = out_word.tens_digit;
  assign ones_digit     = out_word.ones_digit;
  assign slat_id        = out_word.slat_id;
  assign control_id     = out_word.control_id;
  assign persist_strobe = out_word.persist_strobe;

  `TBE_ASSERT_NOW(a_persist_needs_poll, out_valid && persist_strobe,
                  poll_taken && panel_mode == PANEL_BLANK,
                  "persist strobe without a taken poll into idle")
  `TBE_ASSERT_NEXT(a_word_kept, in_full && !adv, in_full,
                   "held poll dropped before it was stepped")

endmodule

FILE: sv/tbe_config.sv
// tbe_config: configuration register file of the two-button ID editor.
// Depends on tbe_pkg.
module tbe_config
  import tbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t wr,
  output cfg_t    cfg
);

  // Decode writes; indexes past the list and the saved IDs leave these alone
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_value       <= RST_MAX_VALUE;
      cfg.idle_timeout_ms <= RST_IDLE_TOUT;
      cfg.debounce_ms     <= RST_DEBOUNCE;
      cfg.repeat_ms       <= RST_REPEAT;
    end else if (wr.we) begin
      unique case (wr.index)
        REG_MAX_VALUE: cfg.max_value       <= wr.data[ID_W-1:0];
        REG_IDLE_TOUT: cfg.idle_timeout_ms <= wr.data[TOUT_W-1:0];
        REG_DEBOUNCE:  cfg.debounce_ms     <= wr.data[INTV_W-1:0];
        REG_REPEAT:    cfg.repeat_ms       <= wr.data[INTV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/tbe_engine.sv
// tbe_engine: editor state and the combinational poll step that forms a result.
// Depends on tbe_pkg and two_button_id_editor_macros.svh.
`include "two_button_id_editor_macros.svh"
module tbe_engine
  import tbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  cfg_wr_t wr,
  input  logic    adv,
  input  item_t   item,
  output res_t    res
);

  logic [MODE_W-1:0] mode, mode_next;
  logic [ID_W-1:0]   slat_value, slat_value_next;
  logic [ID_W-1:0]   control_value, control_value_next;
  logic [TIME_W-1:0] last_poll_time, last_poll_time_next;
  logic [TIME_W-1:0] last_press_time, last_press_time_next;
  logic [INTV_W-1:0] poll_interval, poll_interval_next;

  logic              up_p, down_p, any_p, both_p, held, taken, timed_out, persist;
  logic [TIME_W-1:0] since_poll, since_press;
  logic [ID_W-1:0]   shown;

  // Step one poll against the current state
  always_comb begin
    up_p        = item.up_event != '0;
    down_p      = item.down_event != '0;
    any_p       = up_p || down_p;
    both_p      = up_p && down_p;
    held        = item.up_event[1] || item.down_event[1];
    since_poll  = item.now_ms - last_poll_time;
    since_press = item.now_ms - last_press_time;
    taken       = since_poll >= {{(TIME_W-INTV_W){1'b0}}, poll_interval};
    timed_out   = since_press >= {{(TIME_W-TOUT_W){1'b0}}, cfg.idle_timeout_ms};

    mode_next            = mode;
    slat_value_next      = slat_value;
    control_value_next   = control_value;
    last_poll_time_next  = last_poll_time;
    last_press_time_next = last_press_time;
    poll_interval_next   = poll_interval;
    persist              = 1'b0;

    if (taken) begin
      unique case (mode)
        MODE_IDLE: begin
          if (any_p) begin
            mode_next            = MODE_SLAT;
            last_press_time_next = item.now_ms;
          end
        end
        MODE_SLAT: begin
          if (both_p) begin
            mode_next            = MODE_CTRL;
            poll_interval_next   = cfg.debounce_ms;
            last_press_time_next = item.now_ms;
          end else if (any_p) begin
            slat_value_next = up_p ? step_up(slat_value, cfg.max_value)
                                   : step_down(slat_value, cfg.max_value);
            last_press_time_next = item.now_ms;
          end else if (timed_out) begin
            mode_next            = MODE_CTRL;
            last_press_time_next = item.now_ms;
          end
        end
        MODE_CTRL: begin
          if (both_p) begin
            mode_next = MODE_COMMIT;
          end else if (any_p) begin
            control_value_next = up_p ? step_up(control_value, cfg.max_value)
                                      : step_down(control_value, cfg.max_value);
            last_press_time_next = item.now_ms;
          end else if (timed_out) begin
            mode_next = MODE_COMMIT;
          end
        end
        default: begin
          mode_next          = MODE_IDLE;
          poll_interval_next = cfg.debounce_ms;
          persist            = 1'b1;
        end
      endcase
      // Held buttons switch to the repeat interval; no press restores debounce
      if (any_p) begin
        if (held) poll_interval_next = cfg.repeat_ms;
      end else begin
        poll_interval_next = cfg.debounce_ms;
      end
      last_poll_time_next = item.now_ms;
    end

    // Form the result from the stepped state
    shown              = (mode_next == MODE_SLAT) ? slat_value_next : control_value_next;
    res.poll_taken     = taken;
    res.slat_id        = slat_value_next;
    res.control_id     = control_value_next;
    res.persist_strobe = persist;
    if (mode_next == MODE_IDLE) begin
      res.panel_mode = PANEL_BLANK;
      res.tens_digit = '0;
      res.ones_digit = '0;
    end else begin
      res.panel_mode = (mode_next == MODE_SLAT) ? PANEL_SLAT : PANEL_CTRL;
      res.tens_digit = tens_of(shown);
      res.ones_digit = ones_of(shown);
    end
  end

  // Advance the state on a stepped word; otherwise saved-ID writes load the working IDs
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      slat_value      <= clamp_id(RST_SAVED_ID, RST_MAX_VALUE);
      control_value   <= clamp_id(RST_SAVED_ID, RST_MAX_VALUE);
      last_poll_time  <= '0;
      last_press_time <= '0;
      poll_interval   <= RST_DEBOUNCE;
    end else if (adv) begin
      mode            <= mode_next;
      slat_value      <= slat_value_next;
      control_value   <= control_value_next;
      last_poll_time  <= last_poll_time_next;
      last_press_time <= last_press_time_next;
      poll_interval   <= poll_interval_next;
    end else if (wr.we && wr.index == REG_SAVED_SLAT) begin
      slat_value <= clamp_id(wr.data[ID_W-1:0], cfg.max_value);
    end else if (wr.we && wr.index == REG_SAVED_CTRL) begin
      control_value <= clamp_id(wr.data[ID_W-1:0], cfg.max_value);
    end
  end

  `TBE_ASSERT_NEXT(a_commit_to_idle, adv && taken && mode == MODE_COMMIT,
                   mode == MODE_IDLE, "commit did not return to idle")
  `TBE_ASSERT_NEXT(a_state_holds, !adv && !wr.we,
                   $stable(mode) && $stable(slat_value) && $stable(control_value),
                   "editor state moved without a word or a write")

endmodule

FILE: test/two_button_id_editor_tb.sv
// two_button_id_editor_tb: self-checking bench for the two-button ID editor.
// Depends on tbe_pkg and the two_button_id_editor RTL; drives polls and config
// writes, predicts every result word in-bench and compares field by field.
`timescale 1ns / 1ps

module two_button_id_editor_tb;
  import tbe_pkg::*;

  // Quietest correct stretch is the long receiver hold plus a few short bursts
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 6;
  localparam int TAKEN_PER_PHASE = 195;
  localparam int SCRIPT_ROWS    = 24;

  typedef struct packed {
    logic [EVT_W-1:0]  up;
    logic [EVT_W-1:0]  down;
    logic [TIME_W-1:0] at_ms;
    logic              pinned;
    res_t              want;
  } poll_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [EVT_W-1:0]  up_event;
  logic [EVT_W-1:0]  down_event;
  logic [TIME_W-1:0] now_ms;
  logic              out_valid;
  logic              out_ready;
  logic              poll_taken;
  logic [MODE_W-1:0] panel_mode;
  logic [DIG_W-1:0]  tens_digit;
  logic [DIG_W-1:0]  ones_digit;
  logic [ID_W-1:0]   slat_id;
  logic [ID_W-1:0]   control_id;
  logic              persist_strobe;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // Editor model state and its copy of the registers
  logic [MODE_W-1:0] ed_mode;
  logic [ID_W-1:0]   ed_slat;
  logic [ID_W-1:0]   ed_ctrl;
  logic [TIME_W-1:0] ed_last_poll;
  logic [TIME_W-1:0] ed_last_press;
  logic [INTV_W-1:0] ed_interval;
  logic [ID_W-1:0]   cf_max;
  logic [TOUT_W-1:0] cf_tout;
  logic [INTV_W-1:0] cf_debounce;
  logic [INTV_W-1:0] cf_repeat;

  res_t      pending_results[$];
  poll_row_t script [SCRIPT_ROWS];
  int        errors;
  int        quiet_cycles;
  bit        sender_jitter;
  bit        receiver_jitter;
  bit        hold_request;

  two_button_id_editor dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .up_event       (up_event),
    .down_event     (down_event),
    .now_ms         (now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .poll_taken     (poll_taken),
    .panel_mode     (panel_mode),
    .tens_digit     (tens_digit),
    .ones_digit     (ones_digit),
    .slat_id        (slat_id),
    .control_id     (control_id),
    .persist_strobe (persist_strobe),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Step an ID up, wrapping to zero at or past the maximum
  function automatic logic [ID_W-1:0] id_next(input logic [ID_W-1:0] v);
    return (v >= cf_max) ? '0 : ID_W'(v + 7'd1);
  endfunction

  // Step an ID down, wrapping from zero to the maximum
  function automatic logic [ID_W-1:0] id_prev(input logic [ID_W-1:0] v);
    return (v != '0) ? ID_W'(v - 7'd1) : cf_max;
  endfunction

  // Advance the editor by one poll and form its result word
  task automatic step_editor(input item_t w, output res_t r);
    logic            up_hit;
    logic            dn_hit;
    logic            any_hit;
    logic            both_hit;
    logic            held;
    logic            taken;
    logic            timed_out;
    logic            strobe;
    logic [ID_W-1:0] shown;
    up_hit   = w.up_event != '0;
    dn_hit   = w.down_event != '0;
    any_hit  = up_hit | dn_hit;
    both_hit = up_hit & dn_hit;
    held     = w.up_event[1] | w.down_event[1];
    taken    = (w.now_ms - ed_last_poll) >= TIME_W'(ed_interval);
    strobe   = 1'b0;
    if (taken) begin
      timed_out = (w.now_ms - ed_last_press) >= TIME_W'(cf_tout);
      case (ed_mode)
        MODE_IDLE: begin
          if (any_hit) begin
            ed_mode = MODE_SLAT;
            ed_last_press = w.now_ms;
          end
        end
        MODE_SLAT: begin
          if (both_hit) begin
            ed_mode = MODE_CTRL;
            ed_interval = cf_debounce;
            ed_last_press = w.now_ms;
          end else if (any_hit) begin
            ed_slat = up_hit ? id_next(ed_slat) : id_prev(ed_slat);
            ed_last_press = w.now_ms;
          end else if (timed_out) begin
            ed_mode = MODE_CTRL;
            ed_last_press = w.now_ms;
          end
        end
        MODE_CTRL: begin
          // Leaving for commit keeps the last press time
          if (both_hit) begin
            ed_mode = MODE_COMMIT;
          end else if (any_hit) begin
            ed_ctrl = up_hit ? id_next(ed_ctrl) : id_prev(ed_ctrl);
            ed_last_press = w.now_ms;
          end else if (timed_out) begin
            ed_mode = MODE_COMMIT;
          end
        end
        default: begin
          ed_mode = MODE_IDLE;
          ed_interval = cf_debounce;
          strobe = 1'b1;
        end
      endcase
      // Held press speeds up polling; a poll with no press restores debounce
      if (any_hit) begin
        if (held) ed_interval = cf_repeat;
      end else begin
        ed_interval = cf_debounce;
      end
      ed_last_poll = w.now_ms;
    end
    shown = (ed_mode == MODE_SLAT) ? ed_slat : ed_ctrl;
    r.poll_taken     = taken;
    r.panel_mode     = (ed_mode == MODE_IDLE) ? PANEL_BLANK :
                       (ed_mode == MODE_SLAT) ? PANEL_SLAT : PANEL_CTRL;
    r.tens_digit     = (ed_mode == MODE_IDLE) ? '0 : DIG_W'(shown / 7'd10);
    r.ones_digit     = (ed_mode == MODE_IDLE) ? '0 : DIG_W'(shown % 7'd10);
    r.slat_id        = ed_slat;
    r.control_id     = ed_ctrl;
    r.persist_strobe = strobe;
  endtask

  // Write one register at the next falling edge and mirror it in the model
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_MAX_VALUE:  cf_max = value[ID_W-1:0];
      REG_IDLE_TOUT:  cf_tout = value[TOUT_W-1:0];
      REG_DEBOUNCE:   cf_debounce = value[INTV_W-1:0];
      REG_REPEAT:     cf_repeat = value[INTV_W-1:0];
      REG_SAVED_SLAT: ed_slat = (value[ID_W-1:0] > cf_max) ? '0 : value[ID_W-1:0];
      REG_SAVED_CTRL: ed_ctrl = (value[ID_W-1:0] > cf_max) ? '0 : value[ID_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one poll word, wait for acceptance, then queue its expected result
  task automatic offer_poll(input item_t w, input bit pinned, input res_t want,
                            output bit taken);
    res_t r;
    @(negedge clk);
    if (sender_jitter && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    up_event   <= w.up_event;
    down_event <= w.down_event;
    now_ms     <= w.now_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_editor(w, r);
    pending_results.push_back(pinned ? want : r);
    taken = r.poll_taken;
  endtask

  // Drop valid and let every outstanding result word come back
  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Allow a little margin after the queue empties
    repeat (2) @(posedge clk);
  endtask

  task automatic diff_field(input string label, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      errors++;
    end
  endtask

  // Stimulus: directed script, then random phases under several settings
  initial begin : stimulus
    item_t             w;
    bit                hit;
    int                taken_n;
    int                sent_n;
    int unsigned       kind;
    int unsigned       gap_kind;
    logic [TIME_W-1:0] gap;
    rst             = 1'b1;
    in_valid        = 1'b0;
    up_event        = '0;
    down_event      = '0;
    now_ms          = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_MAX_VALUE;
    cfg_data        = '0;
    errors          = 0;
    sender_jitter   = 1'b1;
    receiver_jitter = 1'b1;
    hold_request    = 1'b0;
    cf_max          = RST_MAX_VALUE;
    cf_tout         = RST_IDLE_TOUT;
    cf_debounce     = RST_DEBOUNCE;
    cf_repeat       = RST_REPEAT;
    ed_mode         = MODE_IDLE;
    ed_slat         = RST_SAVED_ID;
    ed_ctrl         = RST_SAVED_ID;
    ed_last_poll    = '0;
    ed_last_press   = '0;
    ed_interval     = RST_DEBOUNCE;

    // Walk a full edit: open, wrap both ways, timeout, both-buttons, commit
    script[0]  = '{2'd0, 2'd0, 32'd0, 1'b1,
                   '{1'b0, PANEL_BLANK, 4'd0, 4'd0, 7'd0, 7'd0, 1'b0}};
    script[1]  = '{2'd1, 2'd0, 32'd175, 1'b1,
                   '{1'b1, PANEL_SLAT, 4'd0, 4'd0, 7'd0, 7'd0, 1'b0}};
    script[2]  = '{2'd0, 2'd2, 32'd350, 1'b1,
                   '{1'b1, PANEL_SLAT, 4'd9, 4'd9, 7'd99, 7'd0, 1'b0}};
    script[3]  = '{2'd0, 2'd2, 32'd360, 1'b0, '0};
    script[4]  = '{2'd1, 2'd0, 32'd400, 1'b0, '0};
    script[5]  = '{2'd3, 2'd0, 32'd450, 1'b0, '0};
    script[6]  = '{2'd0, 2'd0, 32'd500, 1'b0, '0};
    script[7]  = '{2'd0, 2'd0, 32'd3450, 1'b0, '0};
    script[8]  = '{2'd2, 2'd0, 32'd3625, 1'b0, '0};
    script[9]  = '{2'd0, 2'd1, 32'd3675, 1'b0, '0};
    script[10] = '{2'd0, 2'd1, 32'd3725, 1'b0, '0};
    script[11] = '{2'd1, 2'd1, 32'd3900, 1'b0, '0};
    script[12] = '{2'd0, 2'd0, 32'd3950, 1'b0, '0};
    script[13] = '{2'd1, 2'd1, 32'd4200, 1'b0, '0};
    script[14] = '{2'd1, 2'd1, 32'd4375, 1'b0, '0};
    script[15] = '{2'd2, 2'd2, 32'd4550, 1'b0, '0};
    script[16] = '{2'd0, 2'd0, 32'd4600, 1'b0, '0};
    // Time wraps past 2^32 during an edit
    script[17] = '{2'd1, 2'd0, 32'hFFFF_FFF0, 1'b0, '0};
    script[18] = '{2'd1, 2'd0, 32'h0000_0100, 1'b0, '0};
    script[19] = '{2'd0, 2'd0, 32'h0000_0CB8, 1'b0, '0};
    script[20] = '{2'd0, 2'd0, 32'h0000_1870, 1'b0, '0};
    script[21] = '{2'd0, 2'd0, 32'h0000_191F, 1'b0, '0};
    script[22] = '{2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0, '0};
    script[23] = '{2'd0, 2'd3, 32'h0000_00AE, 1'b0, '0};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        foreach (script[i]) begin
          w.up_event   = script[i].up;
          w.down_event = script[i].down;
          w.now_ms     = script[i].at_ms;
          offer_poll(w, script[i].pinned, script[i].want, hit);
        end
      end else begin
        drain_results;
        case (ph)
          1: begin
            // Upper extremes; saved slat above max loads as zero
            write_reg(REG_MAX_VALUE, 16'd99);
            write_reg(REG_IDLE_TOUT, 16'd65535);
            write_reg(REG_DEBOUNCE, 16'd1000);
            write_reg(REG_REPEAT, 16'd1000);
            write_reg(REG_SAVED_SLAT, 16'd127);
            write_reg(REG_SAVED_CTRL, 16'd99);
          end
          2: begin
            write_reg(REG_MAX_VALUE, 16'd1);
            write_reg(REG_IDLE_TOUT, 16'd1);
            write_reg(REG_DEBOUNCE, 16'd1);
            write_reg(REG_REPEAT, 16'd1);
            write_reg(REG_SAVED_SLAT, 16'd1);
            write_reg(REG_SAVED_CTRL, 16'd0);
          end
          3: begin
            // Load IDs, then shrink max below them; zero intervals take every poll
            write_reg(REG_MAX_VALUE, 16'd99);
            write_reg(REG_SAVED_SLAT, 16'd50);
            write_reg(REG_SAVED_CTRL, 16'd75);
            write_reg(REG_MAX_VALUE, 16'd10);
            write_reg(REG_DEBOUNCE, 16'd0);
            write_reg(REG_REPEAT, 16'd0);
            write_reg(REG_IDLE_TOUT, 16'd0);
          end
          default: begin
            write_reg(REG_MAX_VALUE, DATA_W'($urandom_range(1, 99)));
            write_reg(REG_IDLE_TOUT, DATA_W'($urandom_range(1, 4000)));
            write_reg(REG_DEBOUNCE, DATA_W'($urandom_range(1, 1000)));
            write_reg(REG_REPEAT, DATA_W'($urandom_range(1, 1000)));
            write_reg(REG_SAVED_SLAT, DATA_W'($urandom_range(0, 127)));
            write_reg(REG_SAVED_CTRL, DATA_W'($urandom_range(0, 127)));
            if (ph == 4) write_reg(REG_MAX_VALUE, DATA_W'($urandom_range(1, 99)));
          end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
      end

      // Final phase runs with both sides at full rate
      sender_jitter   = (ph != PHASES - 1);
      receiver_jitter = (ph != PHASES - 1);
      taken_n = 0;
      sent_n  = 0;
      while (taken_n < TAKEN_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        w.up_event   = '0;
        w.down_event = '0;
        if ((kind >= 3 && kind <= 5) || kind == 9) w.up_event = EVT_W'($urandom_range(1, 3));
        if (kind >= 6) w.down_event = EVT_W'($urandom_range(1, 3));
        // Mostly polls that land after the interval; some early, some timeouts
        gap_kind = $urandom_range(0, 19);
        if (gap_kind < 2) begin
          gap = (ed_interval == '0) ? '0 : TIME_W'($urandom_range(0, ed_interval - 1));
        end else if (gap_kind < 4) begin
          gap = TIME_W'(cf_tout) + TIME_W'($urandom_range(0, 200));
          w.up_event   = '0;
          w.down_event = '0;
        end else if (gap_kind == 4) begin
          gap = $urandom;
        end else begin
          gap = TIME_W'(ed_interval) + TIME_W'($urandom_range(0, 30));
        end
        w.now_ms = ed_last_poll + gap;
        if (sent_n == 40 && ph < PHASES - 1) hold_request = 1'b1;
        offer_poll(w, 1'b0, '0, hit);
        sent_n++;
        if (hit) taken_n++;
      end
    end

    drain_results;
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("two_button_id_editor_tb: PASS");
    end else begin
      $display("two_button_id_editor_tb: FAIL");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold per requested phase
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (receiver_jitter && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{poll_taken, panel_mode, tens_digit, ones_digit, slat_id, control_id,
              persist_strobe};
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        diff_field("poll_taken", 32'(want.poll_taken), 32'(got.poll_taken));
        diff_field("panel_mode", 32'(want.panel_mode), 32'(got.panel_mode));
        diff_field("tens_digit", 32'(want.tens_digit), 32'(got.tens_digit));
        diff_field("ones_digit", 32'(want.ones_digit), 32'(got.ones_digit));
        diff_field("slat_id", 32'(want.slat_id), 32'(got.slat_id));
        diff_field("control_id", 32'(want.control_id), 32'(got.control_id));
        diff_field("persist_strobe", 32'(want.persist_strobe), 32'(got.persist_strobe));
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("two_button_id_editor_tb: FAIL");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
+incdir+sv
sv/tbe_pkg.sv
sv/tbe_config.sv
sv/tbe_engine.sv
sv/two_button_id_editor.sv
test/two_button_id_editor_tb.sv
